@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL of the core.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Concurrent assertion on a given clock and active-low reset.
`define ASSERT_AT(lbl, clk_s, rst_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
// Concurrent assertion on the house clock and reset names.
`define ASSERT_STD(lbl, prop, msg) `ASSERT_AT(lbl, clk, arst_n, prop, msg)
`else
`define ASSERT_AT(lbl, clk_s, rst_s, prop, msg)
`define ASSERT_STD(lbl, prop, msg)
`endif
`endif

@@ rtl/core/jsld_pkg.sv @@
// Types, codes and helper functions of the JSON string literal decoder.
// No dependencies; imported by jsld_step and json_string_literal_decoder_core.
`timescale 1ns / 1ps
`default_nettype none

package jsld_pkg;

	// Code units with a special meaning.
	localparam logic [15:0] CU_QUOTE     = 16'h0022;
	localparam logic [15:0] CU_BACKSLASH = 16'h005C;
	localparam logic [15:0] CU_SLASH     = 16'h002F;
	localparam logic [15:0] CU_LC_B      = 16'h0062;
	localparam logic [15:0] CU_LC_F      = 16'h0066;
	localparam logic [15:0] CU_LC_N      = 16'h006E;
	localparam logic [15:0] CU_LC_R      = 16'h0072;
	localparam logic [15:0] CU_LC_T      = 16'h0074;
	localparam logic [15:0] CU_LC_U      = 16'h0075;

	// Control codes that the simple escapes stand for.
	localparam logic [15:0] CC_BS = 16'h0008;
	localparam logic [15:0] CC_FF = 16'h000C;
	localparam logic [15:0] CC_LF = 16'h000A;
	localparam logic [15:0] CC_CR = 16'h000D;
	localparam logic [15:0] CC_HT = 16'h0009;

	// Number of hex digits in a \u escape.
	localparam logic [2:0] HEX_DIGITS = 3'd4;

	// Result kinds.
	localparam logic [1:0] KIND_CHAR     = 2'd0;
	localparam logic [1:0] KIND_CLOSED   = 2'd1;
	localparam logic [1:0] KIND_UNCLOSED = 2'd2;
	localparam logic [1:0] KIND_ERROR    = 2'd3;

	// Error codes.
	localparam logic [2:0] ERR_NO_QUOTE    = 3'd0;
	localparam logic [2:0] ERR_LONE_BSLASH = 3'd1;
	localparam logic [2:0] ERR_TRUNC_U     = 3'd2;
	localparam logic [2:0] ERR_NON_HEX     = 3'd3;
	localparam logic [2:0] ERR_ZERO_VALUE  = 3'd4;
	localparam logic [2:0] ERR_UNKNOWN_ESC = 3'd5;

	// Decoder phase, one-hot.
	typedef enum logic [4:0] {
		PH_AWAIT  = 5'b00001,
		PH_STRING = 5'b00010,
		PH_ESCAPE = 5'b00100,
		PH_HEX    = 5'b01000,
		PH_DONE   = 5'b10000
	} phase_t;

	// Input word.
	typedef struct packed {
		logic [15:0] code_unit;
		logic        end_marker;
	} unit_t;

	// Result word.
	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] char_value;
		logic [15:0] source_index;
		logic [2:0]  error_code;
		logic [15:0] error_start;
		logic [15:0] error_end;
	} result_t;

	// Decoder state that does not depend on the position width.
	typedef struct packed {
		phase_t      phase;
		logic [15:0] hex_accum;
		logic [2:0]  hex_count;
		logic        bad_hex_seen;
	} dec_state_t;

	// True when the code unit is an ASCII hex digit.
	function automatic logic is_hex(input logic [15:0] c);
		return (c >= 16'h0030 && c <= 16'h0039) ||
			(c >= 16'h0061 && c <= 16'h0066) ||
			(c >= 16'h0041 && c <= 16'h0046);
	endfunction

	// Value of a hex digit; only meaningful when is_hex holds.
	function automatic logic [3:0] hex_digit(input logic [15:0] c);
		logic [3:0] d;
		d = c[3:0];
		if (c >= 16'h0030 && c <= 16'h0039) begin
			return d;
		end
		return d + 4'd9;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/jsld_step.sv @@
// Next-state and result logic of the decoder for one input word.
// Depends on jsld_pkg; instantiated by json_string_literal_decoder_core.
`timescale 1ns / 1ps
`default_nettype none

module jsld_step
	import jsld_pkg::*;
#(
	parameter int POSITION_WIDTH = 16
) (
	input  var unit_t                     unit_word,
	input  var dec_state_t                cur,
	input  wire [POSITION_WIDTH-1:0]      pos,
	input  wire [POSITION_WIDTH-1:0]      esc_start,
	output dec_state_t                    nxt,
	output logic [POSITION_WIDTH-1:0]     pos_nxt,
	output logic [POSITION_WIDTH-1:0]     esc_start_nxt,
	output logic                          has_result,
	output result_t                       res
);

	logic [POSITION_WIDTH-1:0]    pos_inc;
	logic [POSITION_WIDTH+15:0]   pos_ext;
	logic [POSITION_WIDTH+15:0]   esc_ext;
	logic [POSITION_WIDTH+15:0]   inc_ext;
	logic [15:0]                  pos16;
	logic [15:0]                  esc16;
	logic [15:0]                  inc16;
	logic [15:0]                  c;
	logic                         digit_ok;
	logic [15:0]                  accum_shift;
	logic [2:0]                   count_inc;

	// Saturating position increment and 16-bit views of the positions.
	assign pos_inc = (pos == {POSITION_WIDTH{1'b1}}) ? pos :
		pos + {{(POSITION_WIDTH-1){1'b0}}, 1'b1};
	assign pos_ext = {16'b0, pos};
	assign esc_ext = {16'b0, esc_start};
	assign inc_ext = {16'b0, pos_inc};
	assign pos16   = pos_ext[15:0];
	assign esc16   = esc_ext[15:0];
	assign inc16   = inc_ext[15:0];

	// Hex digit handling for the \u window.
	assign c           = unit_word.code_unit;
	assign digit_ok    = is_hex(c);
	assign accum_shift = {cur.hex_accum[11:0], hex_digit(c)};
	assign count_inc   = cur.hex_count + 3'd1;

	// One step of the decoder.
	always_comb begin
		nxt           = cur;
		pos_nxt       = pos_inc;
		esc_start_nxt = esc_start;
		has_result    = 1'b0;
		res           = '0;
		if (unit_word.end_marker) begin
			// End of input: report what was left open, then reset.
			unique case (cur.phase)
				PH_AWAIT: begin
					has_result     = 1'b1;
					res.kind       = KIND_ERROR;
					res.error_code = ERR_NO_QUOTE;
				end
				PH_STRING: begin
					has_result       = 1'b1;
					res.kind         = KIND_UNCLOSED;
					res.source_index = pos16;
				end
				PH_ESCAPE: begin
					has_result      = 1'b1;
					res.kind        = KIND_ERROR;
					res.error_code  = ERR_LONE_BSLASH;
					res.error_start = esc16;
					res.error_end   = pos16;
				end
				PH_HEX: begin
					has_result      = 1'b1;
					res.kind        = KIND_ERROR;
					res.error_code  = ERR_TRUNC_U;
					res.error_start = esc16;
					res.error_end   = pos16;
				end
				default: begin
					has_result = 1'b0;
				end
			endcase
			nxt.phase        = PH_AWAIT;
			nxt.hex_accum    = '0;
			nxt.hex_count    = '0;
			nxt.bad_hex_seen = 1'b0;
			pos_nxt          = '0;
			esc_start_nxt    = '0;
		end else begin
			unique case (cur.phase)
				PH_AWAIT: begin
					if (c == CU_QUOTE) begin
						nxt.phase = PH_STRING;
					end else begin
						nxt.phase      = PH_DONE;
						has_result     = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = ERR_NO_QUOTE;
					end
				end
				PH_STRING: begin
					if (c == CU_QUOTE) begin
						nxt.phase        = PH_DONE;
						has_result       = 1'b1;
						res.kind         = KIND_CLOSED;
						res.source_index = pos16;
					end else if (c == CU_BACKSLASH) begin
						nxt.phase     = PH_ESCAPE;
						esc_start_nxt = pos;
					end else begin
						has_result       = 1'b1;
						res.kind         = KIND_CHAR;
						res.char_value   = c;
						res.source_index = pos16;
					end
				end
				PH_ESCAPE: begin
					// Simple escapes give a character; \u opens the hex window; others fail.
					has_result       = 1'b1;
					res.kind         = KIND_CHAR;
					res.source_index = esc16;
					nxt.phase        = PH_STRING;
					if (c == CU_QUOTE || c == CU_BACKSLASH || c == CU_SLASH) begin
						res.char_value = c;
					end else if (c == CU_LC_B) begin
						res.char_value = CC_BS;
					end else if (c == CU_LC_F) begin
						res.char_value = CC_FF;
					end else if (c == CU_LC_N) begin
						res.char_value = CC_LF;
					end else if (c == CU_LC_R) begin
						res.char_value = CC_CR;
					end else if (c == CU_LC_T) begin
						res.char_value = CC_HT;
					end else if (c == CU_LC_U) begin
						has_result       = 1'b0;
						res              = '0;
						nxt.phase        = PH_HEX;
						nxt.hex_accum    = '0;
						nxt.hex_count    = '0;
						nxt.bad_hex_seen = 1'b0;
					end else begin
						nxt.phase       = PH_DONE;
						res             = '0;
						res.kind        = KIND_ERROR;
						res.error_code  = ERR_UNKNOWN_ESC;
						res.error_start = pos16;
						res.error_end   = inc16;
					end
				end
				PH_HEX: begin
					// Collect four digits, then check them and deliver the value or an error.
					nxt.hex_count    = count_inc;
					nxt.bad_hex_seen = cur.bad_hex_seen | ~digit_ok;
					if (digit_ok) begin
						nxt.hex_accum = accum_shift;
					end
					if (count_inc >= HEX_DIGITS) begin
						has_result = 1'b1;
						if (nxt.bad_hex_seen) begin
							nxt.phase       = PH_DONE;
							res.kind        = KIND_ERROR;
							res.error_code  = ERR_NON_HEX;
							res.error_start = esc16;
							res.error_end   = inc16;
						end else if (nxt.hex_accum == 16'h0000) begin
							nxt.phase       = PH_DONE;
							res.kind        = KIND_ERROR;
							res.error_code  = ERR_ZERO_VALUE;
							res.error_start = esc16;
							res.error_end   = inc16;
						end else begin
							nxt.phase        = PH_STRING;
							res.kind         = KIND_CHAR;
							res.char_value   = nxt.hex_accum;
							res.source_index = esc16;
						end
					end
				end
				default: begin
					// Closed or failed: words are dropped until the end marker.
					has_result = 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/json_string_literal_decoder_core.sv @@
// Top level of the JSON string literal decoder: input register, state, result register.
// Depends on jsld_pkg, jsld_step and assert_macros.svh.
//
//   Channel   Handshake                     Word
//   unit      unit_valid / unit_stall       unit_t   (code_unit, end_marker)
//   result    result_valid / result_stall   result_t (kind ... error_end)
//
// One word is taken per cycle while unit_stall is low. A taken word is held in the input register,
// and its result, if it has one, is written to the result register as the word leaves it.
// The decoder state is updated as a word leaves the input register, so a single
// state register loop sets the rate.
// Reset clears the valid flags and the decoder state; no clearing pass is needed.
// A stall on the result side holds the input register, which then stalls the unit side.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module json_string_literal_decoder_core
	import jsld_pkg::*;
#(
	parameter int POSITION_WIDTH = 16
) (
	input  wire     clk,
	input  wire     arst_n,
	input  wire     unit_valid,
	output logic    unit_stall,
	input  var unit_t   unit,
	output logic    result_valid,
	input  wire     result_stall,
	output result_t result
);

	logic                        unit_valid_s1;
	unit_t                       unit_s1;
	logic                        s1_adv;
	logic                        s1_fire;
	dec_state_t                  state_q;
	logic [POSITION_WIDTH-1:0]   pos_q;
	logic [POSITION_WIDTH-1:0]   esc_start_q;
	dec_state_t                  state_nxt;
	logic [POSITION_WIDTH-1:0]   pos_nxt;
	logic [POSITION_WIDTH-1:0]   esc_start_nxt;
	logic                        step_has_result;
	result_t                     step_res;

	// The input register moves on when the result register is empty or being taken.
	assign s1_adv     = ~result_valid | ~result_stall;
	assign s1_fire    = unit_valid_s1 & s1_adv;
	assign unit_stall = unit_valid_s1 & ~s1_adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_valid_s1 <= 1'b0;
		end else if (!unit_stall) begin
			unit_valid_s1 <= unit_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (unit_valid && !unit_stall) begin
			unit_s1 <= unit;
		end
	end

	// Decoder step for the word in the input register.
	jsld_step #(
		.POSITION_WIDTH(POSITION_WIDTH)
	) u_step (
		.unit_word    (unit_s1),
		.cur          (state_q),
		.pos          (pos_q),
		.esc_start    (esc_start_q),
		.nxt          (state_nxt),
		.pos_nxt      (pos_nxt),
		.esc_start_nxt(esc_start_nxt),
		.has_result   (step_has_result),
		.res          (step_res)
	);

	// Decoder state, updated once per word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase        <= PH_AWAIT;
			state_q.hex_accum    <= '0;
			state_q.hex_count    <= '0;
			state_q.bad_hex_seen <= 1'b0;
			pos_q                <= '0;
			esc_start_q          <= '0;
		end else if (s1_fire) begin
			state_q     <= state_nxt;
			pos_q       <= pos_nxt;
			esc_start_q <= esc_start_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (s1_fire && step_has_result) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && step_has_result) begin
			result <= step_res;
		end
	end

	// Checks on the pipeline and the decoder state.
	`ASSERT_STD(a_stall_needs_word, unit_stall |-> unit_valid_s1, "stall without a held word")
	`ASSERT_STD(a_error_ends,
		(s1_fire && step_has_result && !unit_s1.end_marker && step_res.kind == KIND_ERROR)
		|=> (state_q.phase == PH_DONE), "error did not close the literal")
	`ASSERT_STD(a_end_resets, (s1_fire && unit_s1.end_marker) |=> (state_q.phase == PH_AWAIT && pos_q == '0), "end marker did not reset")
	`ASSERT_STD(a_error_fields, (result_valid && result.kind == KIND_ERROR) |-> (result.source_index == 16'h0000 && result.char_value == 16'h0000), "error result carries a character")
	`ASSERT_STD(a_hex_count, (state_q.phase == PH_HEX) |-> (state_q.hex_count < HEX_DIGITS), "hex window overran")

endmodule

`default_nettype wire
